@@ design/scw_pkg.sv @@
// Shared types, constants and widths for the spectrum count weighting block.
package scw_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int THRESH_BITS = 32;
    localparam int WEIGHT_BITS = (COUNT_BITS + 1) / 2 + FRAC_BITS + 1;

    // job operand: a three-point sum needs two bits of headroom
    localparam int VAL_W  = COUNT_BITS + 2;
    localparam int CMP_W  = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;
    // root iterations and radicand width (radicand = operand << 2*FRAC_BITS)
    localparam int ITER   = (COUNT_BITS + 3) / 2 + FRAC_BITS;
    localparam int ITER_W = $clog2(ITER);
    localparam int RAD_W  = 2 * ITER;
    localparam int REM_W  = ITER + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(25);
    localparam logic [ITER-1:0]        ONE_WEIGHT   = ITER'(1) << FRAC_BITS;

    // configuration register indexes
    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN    = 2'd0,
        MODE_PLUS_ONE = 2'd1,
        MODE_PM       = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        JOB_ONE  = 2'd0,  // weight is exactly 1.0
        JOB_ROOT = 2'd1,  // sqrt of operand
        JOB_AVG  = 2'd2   // sqrt of operand / 3
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [VAL_W-1:0] val;
        logic             last;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_CALC  = 2'd1,
        BK_FLUSH = 2'd2
    } back_state_t;

endpackage

@@ design/spectrum_count_weighting.sv @@
// Top level: spectrum channel count weighting (plain, plus-one and Phillips-Marlow).
// Top-level weights come out one job at a time, paced by the bit-serial square root in the
// back end; weights of exactly 1.0 skip the root iterations.
// Inputs are queued as jobs while the back end is busy, so a weight can wait behind earlier jobs.
// Phillips-Marlow mode emits each weight one input later; the last input yields two.
// Reset (rst_n, async, active low): mode 2, threshold 25, queue empty, nothing held.
module spectrum_count_weighting
    import scw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic                   cfg_index,
    input  logic [THRESH_BITS-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COUNT_BITS-1:0]  count_value,
    input  logic                   is_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WEIGHT_BITS-1:0] weight,
    output logic                   last_weight
);

    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    job_t pop_job;
    logic q_empty;

    scw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .count_value (count_value),
        .is_last     (is_last),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full)
    );

    scw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    scw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (pop_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .weight      (weight),
        .last_weight (last_weight)
    );

endmodule

@@ design/scw_front.sv @@
// Front end: config registers, channel history and job classification.
module scw_front
    import scw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic                   cfg_index,
    input  logic [THRESH_BITS-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COUNT_BITS-1:0]  count_value,
    input  logic                   is_last,
    output logic                   push,
    output job_t                   push_job,
    input  logic                   q_full
);

    mode_t                  mode_reg;
    logic [THRESH_BITS-1:0] thr_reg;
    logic [COUNT_BITS-1:0]  before_reg;
    logic [COUNT_BITS-1:0]  held_reg;
    logic                   held_valid_reg;
    logic                   first_reg;
    logic                   pend_valid_reg;
    job_t                   pend_job_reg;

    logic                   in_fire;
    logic                   mid_big;
    logic                   held_big;
    logic [VAL_W-1:0]       sum;
    job_t                   job_held;
    job_t                   job_edge;
    job_t                   first_job;
    logic                   has_job;

    assign in_ready = !pend_valid_reg && !q_full;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        mid_big  = CMP_W'(count_value) >= CMP_W'(thr_reg);
        held_big = CMP_W'(held_reg) >= CMP_W'(thr_reg);
        sum      = VAL_W'(before_reg) + VAL_W'(held_reg) + VAL_W'(count_value);

        // held channel, now that its right neighbor is known
        job_held.last = 1'b0;
        job_held.val  = sum;
        if (held_big)
        begin
            job_held.kind = JOB_ROOT;
            job_held.val  = VAL_W'(held_reg);
        end
        else if (first_reg || sum < VAL_W'(3))
        begin
            job_held.kind = JOB_ONE;
        end
        else
        begin
            job_held.kind = JOB_AVG;
        end

        // final channel is an edge channel
        job_edge.last = 1'b1;
        job_edge.val  = VAL_W'(count_value);
        job_edge.kind = mid_big ? JOB_ROOT : JOB_ONE;

        first_job.kind = JOB_ROOT;
        first_job.last = is_last;
        first_job.val  = VAL_W'(count_value);
        has_job        = 1'b1;
        case (mode_reg)
            MODE_PM:
            begin
                first_job = held_valid_reg ? job_held : job_edge;
                has_job   = held_valid_reg || is_last;
            end
            MODE_PLUS_ONE:
            begin
                first_job.val = VAL_W'(count_value) + VAL_W'(1);
            end
            default:
            begin
                first_job.val = VAL_W'(count_value);
            end
        endcase

        push     = pend_valid_reg ? !q_full : (in_fire && has_job);
        push_job = pend_valid_reg ? pend_job_reg : first_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_PM;
            thr_reg        <= THRESH_RESET;
            held_valid_reg <= 1'b0;
            first_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_MODE)
                begin
                    mode_reg       <= mode_t'(cfg_data[1:0]);
                    held_valid_reg <= 1'b0;
                    first_reg      <= 1'b1;
                end
                else
                begin
                    thr_reg <= cfg_data;
                end
            end
            if (pend_valid_reg && !q_full)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (in_fire)
            begin
                if (mode_reg == MODE_PM)
                begin
                    if (is_last)
                    begin
                        held_valid_reg <= 1'b0;
                        first_reg      <= 1'b1;
                    end
                    else
                    begin
                        held_valid_reg <= 1'b1;
                        if (held_valid_reg)
                        begin
                            first_reg <= 1'b0;
                        end
                    end
                    // two results: the edge job is held in pend_job_reg and pushed once the queue has room
                    if (held_valid_reg && is_last)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                else
                begin
                    first_reg <= is_last;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && mode_reg == MODE_PM)
        begin
            if (held_valid_reg)
            begin
                before_reg <= held_reg;
            end
            held_reg     <= count_value;
            pend_job_reg <= job_edge;
        end
    end

endmodule

@@ design/scw_queue.sv @@
// Small job FIFO between the front end and the root engine.
module scw_queue
    import scw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

@@ design/scw_back.sv @@
// Back end: bit-serial square root with on-the-fly divide by three, output register.
module scw_back
    import scw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  job_t                   q_job,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WEIGHT_BITS-1:0] weight,
    output logic                   last_weight
);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [RAD_W-1:0]       rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ITER-1:0]        root_reg;
    logic [1:0]             drem_reg;
    logic                   avg_reg;
    logic                   last_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic                   out_valid_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic                   last_weight_reg;

    logic                   out_free;
    logic                   iter_done;
    logic [3:0]             t;
    logic [1:0]             qd;
    logic [1:0]             drem_next;
    logic [1:0]             pair;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   take;

    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign weight      = weight_reg;
    assign last_weight = last_weight_reg;
    assign iter_done   = iter_reg == ITER_W'(ITER - 1);

    // radix-4 digit of (radicand / 3), produced MSB first
    always_comb
    begin
        t = {drem_reg, rad_reg[RAD_W-1 -: 2]};
        if (t >= 4'd9)
        begin
            qd        = 2'd3;
            drem_next = 2'(t - 4'd9);
        end
        else if (t >= 4'd6)
        begin
            qd        = 2'd2;
            drem_next = 2'(t - 4'd6);
        end
        else if (t >= 4'd3)
        begin
            qd        = 2'd1;
            drem_next = 2'(t - 4'd3);
        end
        else
        begin
            qd        = 2'd0;
            drem_next = t[1:0];
        end
        pair   = avg_reg ? qd : rad_reg[RAD_W-1 -: 2];
        rem_sh = {rem_reg[REM_W-3:0], pair};
        trial  = {root_reg, 2'b01};
        take   = rem_sh >= trial;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = (q_job.kind == JOB_ONE) ? BK_FLUSH : BK_CALC;
                end
            end
            BK_CALC:
            begin
                if (iter_done)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_FLUSH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                rad_reg  <= RAD_W'(q_job.val) << (2 * FRAC_BITS);
                rem_reg  <= '0;
                root_reg <= (q_job.kind == JOB_ONE) ? ONE_WEIGHT : '0;
                drem_reg <= 2'd0;
                avg_reg  <= q_job.kind == JOB_AVG;
                last_reg <= q_job.last;
                iter_reg <= '0;
            end
            BK_CALC:
            begin
                rad_reg  <= rad_reg << 2;
                drem_reg <= drem_next;
                iter_reg <= iter_reg + ITER_W'(1);
                if (take)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ITER-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ITER-2:0], 1'b0};
                end
            end
            BK_FLUSH:
            begin
                if (out_free)
                begin
                    weight_reg      <= root_reg[WEIGHT_BITS-1:0];
                    last_weight_reg <= last_reg;
                end
            end
            default:
            begin
                iter_reg <= '0;
            end
        endcase
    end

endmodule

@@ design/scw_checker.sv @@
// Port-level assertions for the weighting block, bound to the top level.
module scw_checker
    import scw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [COUNT_BITS-1:0]  count_value,
    input logic                   is_last,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [WEIGHT_BITS-1:0] weight,
    input logic                   last_weight
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(count_value) && $stable(is_last))
        else $error("input changed while stalled");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(last_weight))
        else $error("result changed while stalled");

    // largest weight is exactly a power of two; top bit set means the rest is clear
    a_weight_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && weight[WEIGHT_BITS-1] |-> weight[WEIGHT_BITS-2:0] == '0)
        else $error("weight above range");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // result valid also stays low just after reset release, as every weight must pass through the back end first
    a_reset_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !out_valid)
        else $error("result too soon after reset");

endmodule

bind spectrum_count_weighting scw_checker u_scw_checker (.*);
